### design/dhct_pkg.sv
package dhct_pkg;

  // Default number of table slots.
  localparam int TABLE_DEPTH_DEF = 256;

  // Hash multipliers for the start slot and the probe step.
  localparam logic [31:0] START_MUL = 32'd1905886897;
  localparam logic [31:0] STEP_MUL  = 32'd760092119;

  // Reset value of the table size register.
  localparam logic [3:0] TABLE_BITS_RST = 4'd8;

  // Request kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_ZERO_KEY  = 3'd2;
  localparam logic [2:0] ST_INSERTED  = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // One table slot as held in the store.
  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [7:0]  value;
  } dhct_entry_t;

endpackage

### design/dhct_mac.sv
module dhct_mac #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic [AW-1:0] c,
  output logic [AW-1:0] res
);

  logic [2*AW-1:0] prod;

  // Only the low address bits of the product are ever needed, so the
  // multiply runs on address-wide operands.
  assign prod = a * b;

  // Registered multiply-add, shared by the hash and the probe advance.
  always_ff @(posedge clk) begin
    res <= prod[AW-1:0] + c;
  end

endmodule

### design/dhct_store.sv
module dhct_store #(
  parameter int TABLE_DEPTH = dhct_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  dhct_pkg::dhct_entry_t wr_data,
  input  logic [AW-1:0]         rd_addr,
  output dhct_pkg::dhct_entry_t rd_data,
  output logic                  clear_busy
);
  import dhct_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  dhct_entry_t   mem [TABLE_DEPTH];
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  dhct_entry_t   mem_wd;

  // Clearing pass after reset: one slot per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      if (clr_addr == LAST_ADDR) begin
        clear_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // The clearing pass owns the write port while it runs.
  always_comb begin
    mem_we = clear_busy | wr_en;
    mem_wa = clear_busy ? clr_addr : wr_addr;
    mem_wd = clear_busy ? '0 : wr_data;
  end

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/double_hash_code_table.sv
// Double-hashed code table: maps a nonzero 32-bit key to an 8-bit value.
// Requests come in on the in_valid/in_ready channel (kind, key, value) and
// each produces exactly one result on the out_valid/out_ready channel
// (status, found_value). The table size register is written through
// cfg_we/cfg_wdata and must only be changed while no request is in flight.
// After reset a clearing pass walks the slot memory, one slot a cycle,
// over all TABLE_DEPTH slots; in_ready stays low until it is done. The size
// register resets to 8.
// One request is handled at a time. An accepted request passes through
// S_START, S_STEP and S_READ, then through S_CHECK once per probed slot
// with S_ADV between, and ends in S_FINISH; a zero key goes straight to
// S_FINISH. The block is ready again in the cycle the result appears and
// takes a new request only after the last one has left S_FINISH. Each
// probe is one registered read of the slot memory and one pass through the
// shared multiply-add unit that also computes the start slot and probe step.
// The result sits in an output register; while the receiver stalls the
// block still takes one more request, and holds that one's result until
// the output register is free.
module double_hash_code_table #(
  parameter int TABLE_DEPTH = dhct_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [31:0] key,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [7:0] found_value,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);
  import dhct_pkg::*;

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int MAX_BITS = $clog2(TABLE_DEPTH + 1) - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_STEP,
    S_READ,
    S_CHECK,
    S_ADV,
    S_FINISH
  } state_t;

  state_t        state;
  logic [3:0]    table_bits;
  logic          req_kind;
  logic [31:0]   req_key;
  logic [7:0]    req_value;
  logic [AW-1:0] mask;
  logic [AW-1:0] mask_next;
  logic [AW-1:0] pos;
  logic [AW-1:0] step;
  logic [AW-1:0] cnt;
  logic [2:0]    res_status;
  logic [7:0]    res_value;

  logic [3:0]    eff_bits;
  logic [AW-1:0] mac_a;
  logic [AW-1:0] mac_b;
  logic [AW-1:0] mac_c;
  logic [AW-1:0] mac_res;

  logic          wr_en;
  dhct_entry_t   wr_data;
  logic [AW-1:0] rd_addr;
  dhct_entry_t   rd_data;
  logic          clear_busy;
  logic          in_fire;
  logic          key_hit;

  // Size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_bits <= TABLE_BITS_RST;
    end else if (cfg_we) begin
      table_bits <= cfg_wdata;
    end
  end

  // Slot mask: zero counts as one bit, and the size is capped at the depth.
  always_comb begin
    eff_bits = (table_bits == 4'd0) ? 4'd1 : table_bits;
    if (eff_bits > 4'(MAX_BITS)) begin
      eff_bits = 4'(MAX_BITS);
    end
    mask_next = {AW{1'b1}} >> (AW - int'(eff_bits));
  end

  assign in_ready = (state == S_IDLE) && !clear_busy;
  assign in_fire  = in_valid && in_ready;
  assign key_hit  = (rd_data.key == req_key);

  // Operand selection for the shared multiply-add unit.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    case (state)
      S_START: begin
        mac_a = req_key[AW-1:0];
        mac_b = START_MUL[AW-1:0];
      end
      S_STEP: begin
        mac_a = req_key[AW-1:0];
        mac_b = STEP_MUL[AW-1:0];
      end
      S_CHECK: begin
        mac_a = step;
        mac_b = AW'(1);
        mac_c = pos;
      end
      default: begin
      end
    endcase
  end

  dhct_mac #(
    .AW(AW)
  ) u_mac (
    .clk(clk),
    .a  (mac_a),
    .b  (mac_b),
    .c  (mac_c),
    .res(mac_res)
  );

  // Store access: reads at the current probe slot, inserts on an empty one.
  always_comb begin
    rd_addr       = (state == S_ADV) ? (mac_res & mask) : pos;
    wr_en         = (state == S_CHECK) && !rd_data.used && (req_kind == KIND_INSERT);
    wr_data.used  = 1'b1;
    wr_data.key   = req_key;
    wr_data.value = req_value;
  end

  dhct_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (pos),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .clear_busy(clear_busy)
  );

  // Probe sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The finishing state reloads the output register itself.
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_kind  <= kind;
            req_key   <= key;
            req_value <= value;
            mask      <= mask_next;
            if (key == 32'd0) begin
              res_status <= ST_ZERO_KEY;
              res_value  <= 8'd0;
              state      <= S_FINISH;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_STEP;
        end
        S_STEP: begin
          pos   <= mac_res & mask;
          state <= S_READ;
        end
        S_READ: begin
          step  <= (mac_res & mask) | AW'(1);
          cnt   <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          res_value <= 8'd0;
          if (!rd_data.used) begin
            res_status <= (req_kind == KIND_INSERT) ? ST_INSERTED : ST_NOT_FOUND;
            state      <= S_FINISH;
          end else if (key_hit) begin
            if (req_kind == KIND_INSERT) begin
              res_status <= ST_DUPLICATE;
            end else begin
              res_status <= ST_FOUND;
              res_value  <= rd_data.value;
            end
            state <= S_FINISH;
          end else if (cnt == mask) begin
            // Every active slot probed without a match or a hole.
            res_status <= (req_kind == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
            state      <= S_FINISH;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_ADV;
          end
        end
        S_ADV: begin
          pos   <= mac_res & mask;
          state <= S_CHECK;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found_value <= res_value;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A nonzero value is only ever reported with a found status.
  a_value_only_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_FOUND) |-> found_value == 8'd0)
    else $error("found_value set on a result that is not a hit");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL)
    else $error("undefined status code");

  // A slot check always follows a memory read request.
  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(state) == S_READ || $past(state) == S_ADV)
    else $error("slot checked without a read");

  // Besides clearing, only an insert into an empty slot writes the store.
  a_write_insert: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> req_kind == KIND_INSERT && req_key != 32'd0)
    else $error("store written outside an insert");

  // No new request is taken while the clearing pass runs.
  a_no_req_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !in_ready)
    else $error("request taken during clearing pass");

endmodule

### test/tb_double_hash_code_table.sv
module tb_double_hash_code_table;
  timeunit 1ns;
  timeprecision 1ps;

  import dhct_pkg::*;

  localparam int SLOTS          = TABLE_DEPTH_DEF;
  localparam int N_PHASES       = 12;
  localparam int PHASE_REQUESTS = 125;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;
  localparam int POOL_MAX       = 64;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] found;
  } lookup_result_t;

  typedef enum logic {ROW_REQUEST, ROW_SIZE} row_kind_t;

  typedef struct packed {
    row_kind_t   rk;
    logic        kind;
    logic [31:0] key;
    logic [7:0]  value;
    logic        typed;
    logic [2:0]  status;
    logic [7:0]  found;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [31:0] key;
  logic [7:0]  value;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [7:0]  found_value;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;

  // Mirror of the table and its size register.
  logic [3:0]  mirror_bits;
  logic        mirror_used [SLOTS];
  logic [31:0] mirror_key [SLOTS];
  logic [7:0]  mirror_value [SLOTS];

  lookup_result_t pending_results[$];
  int mismatches;
  int stall_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  logic [3:0]  phase_bits [N_PHASES] = '{4'd1, 4'd3, 4'd0, 4'd2, 4'd5, 4'd15,
                                         4'd4, 4'd6, 4'd9, 4'd7, 4'd2, 4'd8};
  logic [31:0] key_pool [POOL_MAX];
  logic [31:0] edge_keys [3] = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};

  // Directed requests; expected results are typed in only where they are obvious.
  directed_row_t directed_rows [25] = '{
    '{ROW_REQUEST, KIND_LOOKUP, 32'h1234_5678, 8'h00, 1'b1, ST_NOT_FOUND, 8'h00},
    '{ROW_REQUEST, KIND_INSERT, 32'h0000_0000, 8'hFF, 1'b1, ST_ZERO_KEY,  8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'h0000_0000, 8'h00, 1'b1, ST_ZERO_KEY,  8'h00},
    '{ROW_REQUEST, KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_INSERTED,  8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b1, ST_FOUND,     8'hFF},
    '{ROW_REQUEST, KIND_INSERT, 32'hFFFF_FFFF, 8'h00, 1'b1, ST_DUPLICATE, 8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b1, ST_FOUND,     8'hFF},
    '{ROW_REQUEST, KIND_INSERT, 32'h0000_0001, 8'h00, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_INSERT, 32'h8000_0000, 8'h80, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'h0000_0001, 8'h00, 1'b0, ST_FOUND,     8'h00},
    '{ROW_SIZE,    KIND_INSERT, 32'h0000_0000, 8'h01, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_INSERT, 32'h0000_0003, 8'h11, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_INSERT, 32'h0000_0005, 8'h22, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_INSERT, 32'h0000_0007, 8'h33, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'h0000_0009, 8'h00, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0, ST_FOUND,     8'h00},
    '{ROW_SIZE,    KIND_INSERT, 32'h0000_0000, 8'h00, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_INSERT, 32'h0000_000B, 8'h44, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'h0000_0003, 8'h00, 1'b0, ST_FOUND,     8'h00},
    '{ROW_SIZE,    KIND_INSERT, 32'h0000_0000, 8'h0F, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'h0000_0003, 8'h00, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b0, ST_FOUND,     8'h00},
    '{ROW_SIZE,    KIND_INSERT, 32'h0000_0000, 8'h08, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_INSERT, 32'hAAAA_AAAA, 8'h55, 1'b0, ST_FOUND,     8'h00},
    '{ROW_REQUEST, KIND_LOOKUP, 32'h5555_5555, 8'h00, 1'b0, ST_FOUND,     8'h00}
  };

  double_hash_code_table uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_value (found_value),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Number of slots in use for a size register value.
  function automatic int unsigned slots_in_use(logic [3:0] bits);
    int unsigned size;
    size = 1 << ((bits == 4'd0) ? 1 : bits);
    while (size > SLOTS) size = size >> 1;
    return size;
  endfunction

  // Walks the mirror table the way the block probes it, and updates it on insert.
  function automatic lookup_result_t probe_table(logic k, logic [31:0] kk, logic [7:0] v);
    lookup_result_t r;
    int unsigned size;
    int unsigned n;
    logic [31:0] mask;
    logic [31:0] pos;
    logic [31:0] stride;
    r.status = ST_ZERO_KEY;
    r.found  = 8'd0;
    if (kk == 32'd0) return r;
    size   = slots_in_use(mirror_bits);
    mask   = size - 1;
    pos    = (kk * START_MUL) & mask;
    stride = ((kk * STEP_MUL) & mask) | 32'd1;
    r.status = (k == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
    for (n = 0; n < size; n++) begin
      if (!mirror_used[pos]) begin
        if (k == KIND_INSERT) begin
          mirror_used[pos]  = 1'b1;
          mirror_key[pos]   = kk;
          mirror_value[pos] = v;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_NOT_FOUND;
        end
        break;
      end
      if (mirror_key[pos] == kk) begin
        if (k == KIND_INSERT) begin
          r.status = ST_DUPLICATE;
        end else begin
          r.status = ST_FOUND;
          r.found  = mirror_value[pos];
        end
        break;
      end
      pos = (pos + stride) & mask;
    end
    return r;
  endfunction

  // Offers one request, waits for its acceptance and records the expected result.
  // The valid is left high so that a following request can follow back to back.
  task automatic send_request(logic k, logic [31:0] kk, logic [7:0] v,
                              logic typed, lookup_result_t typed_result);
    lookup_result_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    kind     <= k;
    key      <= kk;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    r = probe_table(k, kk, v);
    pending_results.push_back(typed ? typed_result : r);
  endtask

  // Lets every outstanding request finish, then writes the size register.
  task automatic write_table_size(logic [3:0] bits);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= bits;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_bits = bits;
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: status %0d found_value %0d", status, found_value);
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status || found_value !== exp_r.found) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch (status/found_value): expected %0d/%0d, got %0d/%0d",
                     exp_r.status, exp_r.found, status, found_value);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus: directed rows first, then random phases at several table sizes.
  initial begin
    int unsigned p;
    int unsigned i;
    int unsigned pool_n;
    int unsigned size;
    int unsigned pick;
    logic [31:0] kk;
    lookup_result_t typed_result;

    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = KIND_INSERT;
    key            = 32'd0;
    value          = 8'd0;
    cfg_we         = 1'b0;
    cfg_wdata      = 4'd0;
    mismatches     = 0;
    stall_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    mirror_bits    = TABLE_BITS_RST;
    for (i = 0; i < SLOTS; i++) begin
      mirror_used[i]  = 1'b0;
      mirror_key[i]   = 32'd0;
      mirror_value[i] = 8'd0;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[d]) begin
      if (directed_rows[d].rk == ROW_SIZE) begin
        write_table_size(directed_rows[d].value[3:0]);
      end else begin
        typed_result.status = directed_rows[d].status;
        typed_result.found  = directed_rows[d].found;
        send_request(directed_rows[d].kind, directed_rows[d].key, directed_rows[d].value,
                     directed_rows[d].typed, typed_result);
      end
    end

    for (p = 0; p < N_PHASES; p++) begin
      write_table_size(phase_bits[p]);
      send_idle_pct  = (p % 4 == 1) ? 55 : (p % 4 == 3) ? 38 : 0;
      recv_stall_pct = (p % 4 == 2) ? 55 : (p % 4 == 3) ? 38 : 0;

      // A pool a little larger than small tables, so they fill up and overflow.
      size   = slots_in_use(phase_bits[p]);
      pool_n = (size < 32) ? size + size / 2 + 1 : 48;
      for (i = 0; i < pool_n; i++) begin
        kk = $urandom;
        key_pool[i] = (kk == 32'd0) ? 32'd1 : kk;
      end

      for (i = 0; i < PHASE_REQUESTS; i++) begin
        if ((p == 0 || p == 4) && i == 30) hold_req = 1'b1;
        pick = $urandom_range(99);
        if (pick < 4) kk = 32'd0;
        else if (pick < 8) kk = edge_keys[$urandom_range(2)];
        else if (pick < 18) kk = $urandom;
        else kk = key_pool[$urandom_range(pool_n - 1)];
        send_request(1'($urandom_range(1)), kk, 8'($urandom_range(255)), 1'b0,
                     typed_result);
      end
    end

    // Drain and let the block settle before the verdict.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
